// ===== design/idal_pkg.sv =====
// Shared types and codes for the identifier allow-list table.
`default_nettype none

package idal_pkg;

    typedef enum logic [1:0] {
        ST_NOT_FOUND = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_ADDED     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESP
    } t_state;

    typedef enum logic {
        REQ_CHECK  = 1'b0,
        REQ_ENROLL = 1'b1
    } t_req;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    typedef struct packed {
        logic    found;
        t_status status;
    } t_result;

endpackage

`default_nettype wire

// ===== design/idal_mem.sv =====
// Identifier store: single-port synchronous RAM with registered read data.
`default_nettype none

module idal_mem #(
    parameter int DEPTH = 255,
    parameter int AW    = 8
) (
    input  wire logic                i_clk,
    input  wire idal_pkg::t_mem_ctl  i_ctl,
    input  wire logic [AW-1:0]       i_addr,
    input  wire logic [31:0]         i_wr_data,
    output logic      [31:0]         o_rd_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/idal_ctrl.sv =====
// Request sequencer: fill count, linear scan of the store, append on enroll.
`default_nettype none

module idal_ctrl #(
    parameter int CAPACITY = 255,
    parameter int AW       = 8,
    parameter int CW       = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_req_type,
    input  wire logic [31:0]        i_card_id,
    output logic                    o_in_ready,
    output logic                    o_res_valid,
    input  wire logic               i_res_slot_free,
    output idal_pkg::t_result       o_res,
    output idal_pkg::t_mem_ctl      o_mem_ctl,
    output logic      [AW-1:0]      o_mem_addr,
    output logic      [31:0]        o_mem_wr_data,
    input  wire logic [31:0]        i_mem_rd_data
);

    idal_pkg::t_state  r_state, n_state;
    idal_pkg::t_req    r_req, n_req;
    logic [31:0]       r_id, n_id;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_pend, n_pend;
    logic [CW-1:0]     r_count, n_count;
    idal_pkg::t_result r_res, n_res;

    logic          full;
    logic          empty;
    logic          match;
    logic          last_addr;
    idal_pkg::t_req in_req;

    assign in_req    = idal_pkg::t_req'(i_req_type);
    assign full      = (r_count == CW'(CAPACITY));
    assign empty     = (r_count == '0);
    assign match     = r_pend && (i_mem_rd_data == r_id);
    assign last_addr = (r_addr == AW'(r_count - CW'(1)));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            idal_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if ((in_req == idal_pkg::REQ_ENROLL && full) || empty) begin
                        n_state = idal_pkg::S_RESP;
                    end else begin
                        n_state = idal_pkg::S_SCAN;
                    end
                end
            end
            idal_pkg::S_SCAN: begin
                priority if (match) begin
                    n_state = idal_pkg::S_RESP;
                end else if (last_addr) begin
                    n_state = idal_pkg::S_DRAIN;
                end else begin
                    n_state = idal_pkg::S_SCAN;
                end
            end
            idal_pkg::S_DRAIN: begin
                n_state = idal_pkg::S_RESP;
            end
            idal_pkg::S_RESP: begin
                if (i_res_slot_free) begin
                    n_state = idal_pkg::S_IDLE;
                end
            end
            default: n_state = idal_pkg::S_IDLE;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_req   = r_req;
        n_id    = r_id;
        n_addr  = r_addr;
        n_pend  = r_pend;
        n_count = r_count;
        n_res   = r_res;
        unique case (r_state)
            idal_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_req  = in_req;
                    n_id   = i_card_id;
                    n_addr = '0;
                    n_pend = 1'b0;
                    priority if (in_req == idal_pkg::REQ_ENROLL && full) begin
                        n_res = '{found: 1'b0, status: idal_pkg::ST_FULL};
                    end else if (empty) begin
                        if (in_req == idal_pkg::REQ_ENROLL) begin
                            n_count = r_count + CW'(1);
                            n_res   = '{found: 1'b0, status: idal_pkg::ST_ADDED};
                        end else begin
                            n_res = '{found: 1'b0, status: idal_pkg::ST_NOT_FOUND};
                        end
                    end else begin
                        n_res = r_res;
                    end
                end
            end
            idal_pkg::S_SCAN: begin
                n_pend = 1'b1;
                n_addr = r_addr + AW'(1);
                if (match) begin
                    n_pend = 1'b0;
                    n_res  = '{found: 1'b1, status: idal_pkg::ST_PRESENT};
                end
            end
            idal_pkg::S_DRAIN: begin
                n_pend = 1'b0;
                priority if (match) begin
                    n_res = '{found: 1'b1, status: idal_pkg::ST_PRESENT};
                end else if (r_req == idal_pkg::REQ_ENROLL) begin
                    n_count = r_count + CW'(1);
                    n_res   = '{found: 1'b0, status: idal_pkg::ST_ADDED};
                end else begin
                    n_res = '{found: 1'b0, status: idal_pkg::ST_NOT_FOUND};
                end
            end
            idal_pkg::S_RESP: begin
                n_pend = 1'b0;
            end
            default: n_pend = 1'b0;
        endcase
    end

    // Outputs: handshake and memory port
    always_comb begin
        o_in_ready       = 1'b0;
        o_res_valid      = 1'b0;
        o_mem_ctl.rd_en  = 1'b0;
        o_mem_ctl.wr_en  = 1'b0;
        o_mem_addr       = r_addr;
        o_mem_wr_data    = r_id;
        unique case (r_state)
            idal_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_mem_addr    = AW'(r_count);
                o_mem_wr_data = i_card_id;
                o_mem_ctl.wr_en = i_in_valid && empty && (in_req == idal_pkg::REQ_ENROLL);
            end
            idal_pkg::S_SCAN: begin
                o_mem_ctl.rd_en = 1'b1;
            end
            idal_pkg::S_DRAIN: begin
                o_mem_addr      = AW'(r_count);
                o_mem_ctl.wr_en = !match && (r_req == idal_pkg::REQ_ENROLL);
            end
            idal_pkg::S_RESP: begin
                o_res_valid = 1'b1;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idal_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_id   <= n_id;
        r_addr <= n_addr;
        r_res  <= n_res;
    end

endmodule

`default_nettype wire

// ===== design/id_allow_list_table.sv =====
// Top level of the identifier allow-list table.
//
// Keeps up to CAPACITY 32-bit card identifiers in a single-port RAM plus a
// fill count. A check request (req_type 0) searches the filled entries from
// entry 0 and returns found/status (present or not found). An enroll request
// (req_type 1) returns "table full" at once when the count has reached
// CAPACITY, even if the identifier is already stored; otherwise it returns
// "present" without writing, or appends the identifier and returns "newly
// added". One request is in work at a time. A request against an
// empty table, or an enroll into a full one, skips the scan and goes
// straight to its result. Otherwise the scan reads one entry per cycle
// through the RAM's registered read port over the filled entries, and a
// match ends the scan early; an append is written after the last read.
// The result sits in an output register, so the next request is taken while
// the previous result still waits for its transfer. The table starts empty
// after reset; no clearing pass is needed since only filled entries are read.
`default_nettype none

module id_allow_list_table #(
    parameter int CAPACITY = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [31:0] i_card_id,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_found,
    output logic [1:0]       o_status
);

    // Address covers CAPACITY entries; the count must also hold CAPACITY.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    idal_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0]      mem_addr;
    logic [31:0]        mem_wr_data;
    logic [31:0]        mem_rd_data;
    idal_pkg::t_result  res;
    logic               res_valid;
    logic               slot_free;

    logic               r_out_valid;
    idal_pkg::t_result  r_out;

    // The output register can take a new result when empty or being drained.
    assign slot_free = !r_out_valid || i_out_ready;

    idal_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_req_type      (i_req_type),
        .i_card_id       (i_card_id),
        .o_in_ready      (o_in_ready),
        .o_res_valid     (res_valid),
        .i_res_slot_free (slot_free),
        .o_res           (res),
        .o_mem_ctl       (mem_ctl),
        .o_mem_addr      (mem_addr),
        .o_mem_wr_data   (mem_wr_data),
        .i_mem_rd_data   (mem_rd_data)
    );

    idal_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_addr    (mem_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

    // Hold the result until its transfer; load the next one behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out.found;
    assign o_status    = r_out.status;

endmodule

`default_nettype wire
